### sv/cga_graphics_pixel_fetch_unit_defines.svh
// assertion macros for the cga graphics pixel fetch unit
`ifndef CGA_GRAPHICS_PIXEL_FETCH_UNIT_DEFINES_SVH
`define CGA_GRAPHICS_PIXEL_FETCH_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define CGAPF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define CGAPF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/cgapf_pkg.sv
// shared types, codes and color tables for the cga graphics pixel fetch unit
package cgapf_pkg;

  // word command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_HIRES     = 3'd0,
    CFG_PALETTE   = 3'd1,
    CFG_BORDER    = 3'd2,
    CFG_START     = 3'd3,
    CFG_SCROLL_EN = 3'd4,
    CFG_HSCROLL   = 3'd5
  } cfg_idx_t;

  localparam int CFG_IDX_W = 3;

  // screen geometry
  localparam logic [10:0] WIDTH_HI      = 11'd640;
  localparam logic [10:0] WIDTH_LO      = 11'd320;
  localparam logic [7:0]  SCREEN_ROWS   = 8'd200;
  localparam int          SCROLL_W      = 11;
  localparam int          SCROLL_STEPS  = 3;

  // hires foreground colors
  localparam logic [3:0] COLOR_WHITE = 4'hF;
  localparam logic [3:0] COLOR_LGRAY = 4'h7;

  // pixel position info handed to the color stage
  typedef struct packed {
    logic       hires;
    logic [2:0] pos;
  } pix_sel_t;

  typedef struct packed {
    logic [5:0] red;
    logic [5:0] green;
    logic [5:0] blue;
  } rgb_t;

  // 16-entry cga color table
  function automatic rgb_t rgb_of(input logic [3:0] idx);
    rgb_t c;
    case (idx)
      4'd0:    c = '{6'h00, 6'h00, 6'h00};
      4'd1:    c = '{6'h00, 6'h00, 6'h2A};
      4'd2:    c = '{6'h00, 6'h2A, 6'h00};
      4'd3:    c = '{6'h00, 6'h2A, 6'h2A};
      4'd4:    c = '{6'h2A, 6'h00, 6'h00};
      4'd5:    c = '{6'h2A, 6'h00, 6'h2A};
      4'd6:    c = '{6'h2A, 6'h15, 6'h00};
      4'd7:    c = '{6'h2A, 6'h2A, 6'h2A};
      4'd8:    c = '{6'h15, 6'h15, 6'h15};
      4'd9:    c = '{6'h15, 6'h15, 6'h3F};
      4'd10:   c = '{6'h15, 6'h3F, 6'h15};
      4'd11:   c = '{6'h15, 6'h3F, 6'h3F};
      4'd12:   c = '{6'h3F, 6'h15, 6'h15};
      4'd13:   c = '{6'h3F, 6'h15, 6'h3F};
      4'd14:   c = '{6'h3F, 6'h3F, 6'h15};
      default: c = '{6'h3F, 6'h3F, 6'h3F};
    endcase
    return c;
  endfunction

  // low-res sets {2,4,6} {3,5,7} {10,12,14} {11,13,15}
  function automatic logic [3:0] lowres_color(input logic [1:0] psel, input logic [1:0] pix);
    return {psel[1], pix, psel[0]};
  endfunction

endpackage

### sv/cga_graphics_pixel_fetch_unit.sv
// cga graphics pixel fetch top level: five-stage pipeline around the video memory
// a read word passes the stage 1 to stage 4 registers and the output register before it shows on out_valid
// throughput: one word (memory write or pixel read) per cycle unless out_ready stalls, set by the single vram port
// stages: input reg, scroll reduce, column wrap, vram read, output reg
// reset: synchronous active-low rst_n clears valid bits and config registers
// video memory is not cleared and reads as undefined until written
`include "cga_graphics_pixel_fetch_unit_defines.svh"

module cga_graphics_pixel_fetch_unit #(
  parameter int VRAM_BYTES = 16384
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration port
  input  logic                          cfg_we,
  input  logic [cgapf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [$clog2(VRAM_BYTES)-1:0] cfg_wdata,
  // input channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_cmd,
  input  logic [$clog2(VRAM_BYTES)-1:0] in_mem_addr,
  input  logic [7:0]                    in_mem_data,
  input  logic [9:0]                    in_pixel_x,
  input  logic [7:0]                    in_pixel_y,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_color_index,
  output logic [5:0]                    out_red,
  output logic [5:0]                    out_green,
  output logic [5:0]                    out_blue
);

  localparam int          AW       = $clog2(VRAM_BYTES);
  localparam int          ODD_BANK = VRAM_BYTES / 2;
  localparam int          SW       = cgapf_pkg::SCROLL_W;

  // configuration registers
  logic          hires_r;
  logic [1:0]    palette_r;
  logic [3:0]    border_r;
  logic [AW-1:0] start_r;
  logic          scroll_en_r;
  logic [SW-1:0] hscroll_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hires_r     <= 1'b0;
      palette_r   <= '0;
      border_r    <= '0;
      start_r     <= '0;
      scroll_en_r <= 1'b0;
      hscroll_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        cgapf_pkg::CFG_HIRES:     hires_r     <= cfg_wdata[0];
        cgapf_pkg::CFG_PALETTE:   palette_r   <= cfg_wdata[1:0];
        cgapf_pkg::CFG_BORDER:    border_r    <= cfg_wdata[3:0];
        cgapf_pkg::CFG_START:     start_r     <= cfg_wdata;
        cgapf_pkg::CFG_SCROLL_EN: scroll_en_r <= cfg_wdata[0];
        cgapf_pkg::CFG_HSCROLL:   hscroll_r   <= cfg_wdata[SW-1:0];
        default: ;
      endcase
    end
  end

  logic [10:0] width;
  assign width = hires_r ? cgapf_pkg::WIDTH_HI : cgapf_pkg::WIDTH_LO;

  // stage valid bits and per-stage advance enables
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, out_valid_r;
  logic en1, en2, en3, en4;

  assign en4      = !out_valid_r || out_ready;
  assign en3      = !s4_v_r || en4;
  assign en2      = !s3_v_r || en3;
  assign en1      = !s2_v_r || en2;
  assign in_ready = !s1_v_r || en1;

  // stage 1: input register
  logic          s1_cmd_r;
  logic [AW-1:0] s1_addr_r;
  logic [7:0]    s1_data_r;
  logic [9:0]    s1_x_r;
  logic [7:0]    s1_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ready) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      s1_cmd_r  <= in_cmd;
      s1_addr_r <= in_mem_addr;
      s1_data_r <= in_mem_data;
      s1_x_r    <= in_pixel_x;
      s1_y_r    <= in_pixel_y;
    end
  end

  // stage 1 logic: screen bounds and scroll magnitude reduced below the width
  logic [SW-1:0] raw_scroll;
  logic          s2_neg_nxt;
  logic [SW-1:0] mag;
  logic          on_screen;
  logic          s2_v_nxt;

  always_comb begin
    raw_scroll = scroll_en_r ? hscroll_r : '0;
    s2_neg_nxt = raw_scroll[SW-1];
    mag        = s2_neg_nxt ? (SW'(0) - raw_scroll) : raw_scroll;
    for (int i = 0; i < cgapf_pkg::SCROLL_STEPS; i++) begin
      if (mag >= width) begin
        mag = mag - width;
      end
    end
  end

  assign on_screen = ({1'b0, s1_x_r} < width) && (s1_y_r < cgapf_pkg::SCREEN_ROWS);
  assign s2_v_nxt  = s1_v_r && ((s1_cmd_r == cgapf_pkg::CMD_WRITE) || on_screen);

  // stage 2 register
  logic          s2_cmd_r;
  logic [AW-1:0] s2_addr_r;
  logic [7:0]    s2_data_r;
  logic [9:0]    s2_x_r;
  logic [7:0]    s2_y_r;
  logic [9:0]    s2_mag_r;
  logic          s2_neg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en1) begin
      s2_v_r <= s2_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s2_cmd_r  <= s1_cmd_r;
      s2_addr_r <= s1_addr_r;
      s2_data_r <= s1_data_r;
      s2_x_r    <= s1_x_r;
      s2_y_r    <= s1_y_r;
      s2_mag_r  <= mag[9:0];
      s2_neg_r  <= s2_neg_nxt;
    end
  end

  // stage 2 logic: scrolled column wrapped once into the screen
  logic [10:0] xs, ms, sum, src_x;

  always_comb begin
    xs  = {1'b0, s2_x_r};
    ms  = {1'b0, s2_mag_r};
    sum = xs + ms;
    if (s2_neg_r) begin
      src_x = (xs >= ms) ? (xs - ms) : (xs + width - ms);
    end else begin
      src_x = (sum >= width) ? (sum - width) : sum;
    end
  end

  // stage 3 register
  logic          s3_cmd_r;
  logic [AW-1:0] s3_addr_r;
  logic [7:0]    s3_data_r;
  logic [9:0]    s3_src_x_r;
  logic [7:0]    s3_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en2) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s3_cmd_r   <= s2_cmd_r;
      s3_addr_r  <= s2_addr_r;
      s3_data_r  <= s2_data_r;
      s3_src_x_r <= src_x[9:0];
      s3_y_r     <= s2_y_r;
    end
  end

  // stage 3 logic: interlaced byte address, odd rows in the upper bank
  logic [6:0]    row_pair;
  logic [AW-1:0] bank, row_off, col, pix_addr, vram_addr;
  logic          s3_write;

  always_comb begin
    row_pair  = s3_y_r[7:1];
    bank      = s3_y_r[0] ? AW'(ODD_BANK) : '0;
    row_off   = AW'({row_pair, 6'b0}) + AW'({row_pair, 4'b0});
    col       = hires_r ? AW'(s3_src_x_r[9:3]) : AW'(s3_src_x_r[9:2]);
    pix_addr  = bank + row_off + start_r + col;
    s3_write  = s3_cmd_r == cgapf_pkg::CMD_WRITE;
    vram_addr = s3_write ? s3_addr_r : pix_addr;
  end

  logic [7:0] rd_byte;

  cgapf_vram #(
    .AW (AW)
  ) u_vram (
    .clk   (clk),
    .en    (en3),
    .we    (s3_v_r && s3_write),
    .addr  (vram_addr),
    .wdata (s3_data_r),
    .rdata (rd_byte)
  );

  // stage 4 register, alongside the vram read data; writes end here
  cgapf_pkg::pix_sel_t s4_sel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (en3) begin
      s4_v_r <= s3_v_r && !s3_write;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      s4_sel_r <= '{hires: hires_r, pos: s3_src_x_r[2:0]};
    end
  end

  // stage 4 logic: pixel extraction and palette
  logic [1:0]      pix_idx;
  cgapf_pkg::rgb_t pix_rgb;

  cgapf_color u_color (
    .data_byte_i    (s4_v_r),
    .data_byte      (rd_byte),
    .sel            (s4_sel_r),
    .palette_select (palette_r),
    .border_color   (border_r),
    .color_index    (pix_idx),
    .rgb            (pix_rgb)
  );

  // output register
  logic [1:0]      out_idx_r;
  cgapf_pkg::rgb_t out_rgb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en4) begin
      out_valid_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      out_idx_r <= pix_idx;
      out_rgb_r <= pix_rgb;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_color_index = out_idx_r;
  assign out_red         = out_rgb_r.red;
  assign out_green       = out_rgb_r.green;
  assign out_blue        = out_rgb_r.blue;

  // checks
  `CGAPF_ASSERT_IMP(a_full_blocks_input, clk, rst_n,
    out_valid_r && !out_ready && s4_v_r && s3_v_r && s2_v_r && s1_v_r, !in_ready,
    "input accepted while the whole pipeline is stalled")
  `CGAPF_ASSERT_NXT(a_read_data_held, clk, rst_n, s4_v_r && !en4, $stable(rd_byte),
    "vram read data changed under a stalled pixel")
  `CGAPF_ASSERT_NXT(a_accept_fills_s1, clk, rst_n, in_valid && in_ready, s1_v_r,
    "accepted word did not enter the first stage")

endmodule

### sv/cgapf_vram.sv
// video memory with one write or registered read per cycle while en is high
module cgapf_vram #(
  parameter int AW = 14
) (
  input  logic          clk,
  input  logic          en,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [7:0]    wdata,
  output logic [7:0]    rdata
);

  logic [7:0] mem [2**AW];
  logic [7:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (en && we) begin
      mem[addr] <= wdata;
    end
  end

  // registered read port, holds while stalled
  always_ff @(posedge clk) begin
    if (en) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

### sv/cgapf_color.sv
// pixel extraction from a fetched byte and palette lookup
module cgapf_color (
  input  logic                data_byte_i,
  input  logic [7:0]          data_byte,
  input  cgapf_pkg::pix_sel_t sel,
  input  logic [1:0]          palette_select,
  input  logic [3:0]          border_color,
  output logic [1:0]          color_index,
  output cgapf_pkg::rgb_t     rgb
);

  logic [1:0] pix;
  logic [3:0] pal_idx;

  // pick the pixel bits, leftmost pixel in the top bits
  always_comb begin
    if (sel.hires) begin
      pix = {1'b0, data_byte[~sel.pos]};
    end else begin
      case (sel.pos[1:0])
        2'd0:    pix = data_byte[7:6];
        2'd1:    pix = data_byte[5:4];
        2'd2:    pix = data_byte[3:2];
        default: pix = data_byte[1:0];
      endcase
    end
  end

  // palette: zero shows the border color
  always_comb begin
    if (pix == 2'd0) begin
      pal_idx = border_color;
    end else if (sel.hires) begin
      pal_idx = palette_select[1] ? cgapf_pkg::COLOR_WHITE : cgapf_pkg::COLOR_LGRAY;
    end else begin
      pal_idx = cgapf_pkg::lowres_color(palette_select, pix);
    end
  end

  assign color_index = pix & {2{data_byte_i}};
  assign rgb         = cgapf_pkg::rgb_of(pal_idx);

endmodule
